### sv/ptb_pkg.sv
// Shared types and codes for the periodic timer bank.
`default_nettype none
package ptb_pkg;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_DELETE  = 4'd1,
    OP_START   = 4'd2,
    OP_STOP    = 4'd3,
    OP_PAUSE   = 4'd4,
    OP_RESUME  = 4'd5,
    OP_SET_PER = 4'd6,
    OP_SET_LPS = 4'd7,
    OP_READ    = 4'd8,
    OP_TICK    = 4'd9,
    OP_FLUSH   = 4'd10
  } op_t;

  localparam logic [3:0] OP_LAST = OP_FLUSH;

  typedef enum logic [2:0] {
    RS_OK          = 3'd0,
    RS_INVALID     = 3'd1,
    RS_DISABLED    = 3'd2,
    RS_FULL        = 3'd3,
    RS_NOT_FOUND   = 3'd4,
    RS_ALREADY     = 3'd5,
    RS_NOT_RUNNING = 3'd6
  } rs_t;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_STOPPED = 3'd1,
    ST_RUNNING = 3'd2,
    ST_PAUSED  = 3'd3,
    ST_EXPIRED = 3'd4
  } slot_st_t;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_FIRE = 1'b1;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_IN_USE = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CMD  = 7'b0000010,
    S_FIND = 7'b0000100,
    S_WALK = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_RESP = 7'b1000000
  } fsm_t;

endpackage
`default_nettype wire

### sv/ptb_div.sv
// Restoring 64-by-32 divider, one quotient bit per cycle.
`default_nettype none
module ptb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [6:0]  count;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quotient[63]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial;
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[62:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### sv/periodic_timer_bank_top.sv
// Top level of the periodic timer bank: command sequencer and slot storage.
// Commands other than create, tick, flush and a running set period go from S_CMD straight
// to S_RESP, which holds until the output is free. Create scans slots one per cycle for the
// first free one; tick and flush walk the live slots one per cycle, stalling while a fire
// event waits on the output. A set period on a running timer multiplies in S_MUL and then
// waits in S_DIV on the bit-serial divider. A new item is taken only after the response of
// the previous one has been loaded for output.
`default_nettype none
module periodic_timer_bank_top
  import ptb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  target,
  input  wire logic [31:0] period,
  input  wire logic [31:0] loop_limit,
  input  wire logic        delayed_mode,
  input  wire logic [31:0] elapsed_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [2:0]       status,
  output logic [5:0]       slot,
  output logic [31:0]      remaining,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [5:0] NT = 6'(NUM_TIMERS);

  fsm_t fsm;
  logic enable;
  logic [5:0] timers_in_use;
  logic [5:0] n_eff;

  slot_st_t    slot_state   [NUM_TIMERS];
  logic        slot_pending [NUM_TIMERS];
  logic        slot_delayed [NUM_TIMERS];
  logic [31:0] slot_period  [NUM_TIMERS];
  logic [31:0] slot_rem     [NUM_TIMERS];
  logic [31:0] slot_limit   [NUM_TIMERS];
  logic [31:0] slot_left    [NUM_TIMERS];

  logic [3:0]  op_q;
  logic [5:0]  id_q;
  logic [31:0] per_q;
  logic [31:0] loops_q;
  logic        dly_q;
  logic [31:0] el_q;
  logic [5:0]  idx;

  rs_t         resp_status;
  logic [5:0]  resp_slot;
  logic [31:0] resp_rem;

  logic [31:0] mul_a;
  logic [31:0] old_per;
  logic [63:0] prod;
  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [63:0] quot;
  logic [31:0] quot_sat;

  logic [5:0]     sel;
  logic [IW-1:0]  sx;
  slot_st_t       cur_st;
  logic           found;
  logic           out_free;
  logic           fire_load;
  logic           resp_load;
  logic [31:0]    left_dec;

  assign n_eff    = (timers_in_use < NT) ? timers_in_use : NT;
  assign sel      = (fsm == S_FIND || fsm == S_WALK) ? idx : id_q;
  assign sx       = sel[IW-1:0];
  assign cur_st   = slot_state[sx];
  assign found    = (id_q < n_eff) &&
                    (op_q == OP_PAUSE || op_q == OP_RESUME || cur_st != ST_UNUSED);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (fsm == S_IDLE);
  assign left_dec = slot_left[sx] - 32'd1;
  assign quot_sat = (quot[63:32] != 32'd0) ? 32'hFFFF_FFFF :
                    (quot[31:0] == 32'd0) ? 32'd1 : quot[31:0];

  always_comb begin
    fire_load = 1'b0;
    if (fsm == S_WALK && idx < n_eff && out_free) begin
      if (op_q == OP_TICK) begin
        fire_load = (cur_st == ST_RUNNING) && (slot_rem[sx] <= el_q) && !slot_delayed[sx];
      end else begin
        fire_load = slot_pending[sx];
      end
    end
  end
  assign resp_load = (fsm == S_RESP) && out_free;

  ptb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (old_per),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_IDLE;
      enable        <= 1'b0;
      timers_in_use <= 6'd16;
      div_start     <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_state[i]   <= ST_UNUSED;
        slot_pending[i] <= 1'b0;
      end
    end else begin
      div_start <= (fsm == S_MUL);
      unique case (fsm)
        S_IDLE: begin
          if (in_valid) begin
            fsm <= S_CMD;
          end
        end
        S_CMD: begin
          fsm <= S_RESP;
          if (op_q > OP_LAST) begin
          end else if (!enable) begin
          end else begin
            unique case (op_q)
              OP_CREATE: begin
                if (per_q != 32'd0) begin
                  fsm <= S_FIND;
                end
              end
              OP_TICK, OP_FLUSH: fsm <= S_WALK;
              OP_DELETE: begin
                if (found) begin
                  slot_state[sx] <= ST_UNUSED;
                end
              end
              OP_START: begin
                if (found && cur_st != ST_RUNNING) begin
                  slot_state[sx] <= ST_RUNNING;
                end
              end
              OP_STOP: begin
                if (found && cur_st != ST_STOPPED) begin
                  slot_state[sx] <= ST_STOPPED;
                end
              end
              OP_PAUSE: begin
                if (found && cur_st == ST_RUNNING) begin
                  slot_state[sx] <= ST_PAUSED;
                end
              end
              OP_RESUME: begin
                if (found && cur_st == ST_PAUSED) begin
                  slot_state[sx] <= ST_RUNNING;
                end
              end
              OP_SET_PER: begin
                if (per_q != 32'd0 && found && cur_st == ST_RUNNING &&
                    slot_period[sx] != 32'd0) begin
                  fsm <= S_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FIND: begin
          if (idx >= n_eff) begin
            fsm <= S_RESP;
          end else if (cur_st == ST_UNUSED) begin
            slot_state[sx]   <= ST_STOPPED;
            slot_pending[sx] <= 1'b0;
            fsm              <= S_RESP;
          end
        end
        S_WALK: begin
          if (idx >= n_eff) begin
            fsm <= S_RESP;
          end else if (out_free) begin
            if (op_q == OP_TICK) begin
              if (cur_st == ST_RUNNING && slot_rem[sx] <= el_q) begin
                if (slot_limit[sx] != 32'd0 && left_dec == 32'd0) begin
                  slot_state[sx] <= ST_EXPIRED;
                end
                if (slot_delayed[sx]) begin
                  slot_pending[sx] <= 1'b1;
                end
              end
            end else begin
              slot_pending[sx] <= 1'b0;
            end
          end
        end
        S_MUL: fsm <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            fsm <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          enable <= cfg_data[0];
          for (int i = 0; i < NUM_TIMERS; i++) begin
            slot_state[i]   <= ST_UNUSED;
            slot_pending[i] <= 1'b0;
          end
        end else begin
          timers_in_use <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (fsm)
      S_IDLE: begin
        op_q    <= opcode;
        id_q    <= target;
        per_q   <= period;
        loops_q <= loop_limit;
        dly_q   <= delayed_mode;
        el_q    <= elapsed_ms;
        idx     <= '0;
      end
      S_CMD: begin
        resp_slot   <= '0;
        resp_rem    <= '0;
        resp_status <= RS_OK;
        if (op_q > OP_LAST) begin
          resp_status <= RS_INVALID;
        end else if (!enable) begin
          resp_status <= RS_DISABLED;
        end else begin
          unique case (op_q)
            OP_CREATE: begin
              if (per_q == 32'd0) begin
                resp_status <= RS_INVALID;
              end
            end
            OP_TICK, OP_FLUSH: begin
            end
            OP_DELETE: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end
            end
            OP_START: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else if (cur_st == ST_RUNNING) begin
                resp_status <= RS_ALREADY;
              end else begin
                slot_rem[sx] <= slot_period[sx];
                if (slot_limit[sx] != 32'd0) begin
                  slot_left[sx] <= slot_limit[sx];
                end
              end
            end
            OP_STOP: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else if (cur_st == ST_STOPPED) begin
                resp_status <= RS_NOT_RUNNING;
              end else begin
                slot_rem[sx] <= slot_period[sx];
              end
            end
            OP_PAUSE: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else if (cur_st != ST_RUNNING) begin
                resp_status <= RS_NOT_RUNNING;
              end
            end
            OP_RESUME: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else if (cur_st != ST_PAUSED) begin
                resp_status <= RS_NOT_RUNNING;
              end
            end
            OP_SET_PER: begin
              if (per_q == 32'd0) begin
                resp_status <= RS_INVALID;
              end else if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else begin
                slot_period[sx] <= per_q;
                old_per         <= slot_period[sx];
                mul_a           <= slot_rem[sx];
              end
            end
            OP_SET_LPS: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else begin
                slot_limit[sx] <= loops_q;
                slot_left[sx]  <= loops_q;
              end
            end
            OP_READ: begin
              if (!found) begin
                resp_status <= RS_NOT_FOUND;
              end else begin
                resp_rem <= slot_rem[sx];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND: begin
        if (idx >= n_eff) begin
          resp_status <= RS_FULL;
        end else if (cur_st == ST_UNUSED) begin
          slot_period[sx]  <= per_q;
          slot_rem[sx]     <= per_q;
          slot_limit[sx]   <= loops_q;
          slot_left[sx]    <= loops_q;
          slot_delayed[sx] <= dly_q;
          resp_slot        <= idx;
        end else begin
          idx <= idx + 6'd1;
        end
      end
      S_WALK: begin
        if (idx < n_eff && out_free) begin
          idx <= idx + 6'd1;
          if (op_q == OP_TICK && cur_st == ST_RUNNING) begin
            if (slot_rem[sx] > el_q) begin
              slot_rem[sx] <= slot_rem[sx] - el_q;
            end else begin
              if (slot_limit[sx] != 32'd0) begin
                slot_left[sx] <= left_dec;
              end
              if (slot_limit[sx] != 32'd0 && left_dec == 32'd0) begin
                slot_rem[sx] <= 32'd0;
              end else begin
                slot_rem[sx] <= slot_period[sx];
              end
            end
          end
        end
      end
      S_MUL: prod <= 64'(mul_a) * 64'(per_q);
      S_DIV: begin
        if (div_done) begin
          slot_rem[sx] <= quot_sat;
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire_load || resp_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_load) begin
      kind      <= KIND_FIRE;
      status    <= RS_OK;
      slot      <= idx;
      remaining <= '0;
      last      <= 1'b0;
    end else if (resp_load) begin
      kind      <= KIND_RESP;
      status    <= resp_status;
      slot      <= resp_slot;
      remaining <= resp_rem;
      last      <= 1'b1;
    end
  end

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> fsm == S_DIV)
    else $error("divider busy outside division state");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    fsm == S_WALK |-> idx <= n_eff)
    else $error("slot walk beyond live count");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> fsm == S_CMD)
    else $error("accepted item not decoded");

endmodule
`default_nettype wire

### sim/periodic_timer_bank_checker.sv
// Checker for the periodic timer bank: predicts the results of every item and compares them.
`timescale 1ns / 1ps
module periodic_timer_bank_checker
  import ptb_pkg::*;
#(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  opcode,
  input  logic [5:0]  target,
  input  logic [31:0] period,
  input  logic [31:0] loop_limit,
  input  logic        delayed_mode,
  input  logic [31:0] elapsed_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        kind,
  input  logic [2:0]  status,
  input  logic [5:0]  slot,
  input  logic [31:0] remaining,
  input  logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef struct packed {
    logic        kind;
    rs_t         status;
    logic [5:0]  slot;
    logic [31:0] rem;
    logic        last;
  } timer_result_t;

  timer_result_t due_q[$];

  logic        bank_on;
  logic [5:0]  in_use;
  slot_st_t    tmr_state[NUM_TIMERS];
  logic [31:0] tmr_period[NUM_TIMERS];
  logic [31:0] tmr_rem[NUM_TIMERS];
  logic [31:0] tmr_limit[NUM_TIMERS];
  logic [31:0] tmr_left[NUM_TIMERS];
  logic        tmr_delayed[NUM_TIMERS];
  logic        tmr_pending[NUM_TIMERS];

  function automatic void clear_timers();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_state[i] = ST_UNUSED;
      tmr_period[i] = '0;
      tmr_rem[i] = '0;
      tmr_limit[i] = '0;
      tmr_left[i] = '0;
      tmr_delayed[i] = 1'b0;
      tmr_pending[i] = 1'b0;
    end
  endfunction

  function automatic void add_fire(int i);
    timer_result_t r;
    r = '{kind: KIND_FIRE, status: RS_OK, slot: 6'(i), rem: '0, last: 1'b0};
    due_q.push_back(r);
  endfunction

  function automatic void run_command(logic [3:0] op, logic [5:0] id, logic [31:0] per,
                                      logic [31:0] loops, logic dly, logic [31:0] el);
    int n;
    int i;
    bit found;
    bit keep;
    rs_t st;
    logic [5:0] rslot;
    logic [31:0] rrem;
    logic [31:0] old;
    logic [63:0] q;
    timer_result_t r;
    n = (in_use < NUM_TIMERS) ? in_use : NUM_TIMERS;
    st = RS_OK;
    rslot = '0;
    rrem = '0;
    found = id < n;
    if (op > OP_LAST) begin
      st = RS_INVALID;
    end else if (!bank_on) begin
      st = RS_DISABLED;
    end else begin
      if (found && op inside {OP_DELETE, OP_START, OP_STOP, OP_SET_PER, OP_SET_LPS, OP_READ}
          && tmr_state[id] == ST_UNUSED)
        found = 0;
      case (op)
        OP_CREATE: begin
          if (per == 0) st = RS_INVALID;
          else begin
            for (i = 0; i < n; i++)
              if (tmr_state[i] == ST_UNUSED) break;
            if (i >= n) st = RS_FULL;
            else begin
              tmr_state[i] = ST_STOPPED;
              tmr_period[i] = per;
              tmr_rem[i] = per;
              tmr_limit[i] = loops;
              tmr_left[i] = loops;
              tmr_delayed[i] = dly;
              tmr_pending[i] = 1'b0;
              rslot = 6'(i);
            end
          end
        end
        OP_DELETE: begin
          if (!found) st = RS_NOT_FOUND;
          else tmr_state[id] = ST_UNUSED;
        end
        OP_START: begin
          if (!found) st = RS_NOT_FOUND;
          else if (tmr_state[id] == ST_RUNNING) st = RS_ALREADY;
          else begin
            tmr_state[id] = ST_RUNNING;
            tmr_rem[id] = tmr_period[id];
            if (tmr_limit[id] > 0) tmr_left[id] = tmr_limit[id];
          end
        end
        OP_STOP: begin
          if (!found) st = RS_NOT_FOUND;
          else if (tmr_state[id] == ST_STOPPED) st = RS_NOT_RUNNING;
          else begin
            tmr_state[id] = ST_STOPPED;
            tmr_rem[id] = tmr_period[id];
          end
        end
        OP_PAUSE: begin
          if (!found) st = RS_NOT_FOUND;
          else if (tmr_state[id] != ST_RUNNING) st = RS_NOT_RUNNING;
          else tmr_state[id] = ST_PAUSED;
        end
        OP_RESUME: begin
          if (!found) st = RS_NOT_FOUND;
          else if (tmr_state[id] != ST_PAUSED) st = RS_NOT_RUNNING;
          else tmr_state[id] = ST_RUNNING;
        end
        OP_SET_PER: begin
          if (per == 0) st = RS_INVALID;
          else if (!found) st = RS_NOT_FOUND;
          else begin
            old = tmr_period[id];
            tmr_period[id] = per;
            if (tmr_state[id] == ST_RUNNING && old != 0) begin
              q = (64'(tmr_rem[id]) * 64'(per)) / 64'(old);
              if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
              if (q == 0) q = 64'd1;
              tmr_rem[id] = q[31:0];
            end
          end
        end
        OP_SET_LPS: begin
          if (!found) st = RS_NOT_FOUND;
          else begin
            tmr_limit[id] = loops;
            tmr_left[id] = loops;
          end
        end
        OP_READ: begin
          if (!found) st = RS_NOT_FOUND;
          else rrem = tmr_rem[id];
        end
        OP_TICK: begin
          for (i = 0; i < n; i++) begin
            if (tmr_state[i] != ST_RUNNING) continue;
            if (tmr_rem[i] > el) begin
              tmr_rem[i] = tmr_rem[i] - el;
              continue;
            end
            keep = 1;
            tmr_rem[i] = '0;
            if (tmr_limit[i] > 0) begin
              tmr_left[i] = tmr_left[i] - 1;
              if (tmr_left[i] == 0) begin
                keep = 0;
                tmr_state[i] = ST_EXPIRED;
              end
            end
            if (tmr_delayed[i]) tmr_pending[i] = 1'b1;
            else add_fire(i);
            if (keep) tmr_rem[i] = tmr_period[i];
          end
        end
        default: begin
          for (i = 0; i < n; i++) begin
            if (!tmr_pending[i]) continue;
            tmr_pending[i] = 1'b0;
            add_fire(i);
          end
        end
      endcase
    end
    r = '{kind: KIND_RESP, status: st, slot: rslot, rem: rrem, last: 1'b1};
    due_q.push_back(r);
  endfunction

  always @(posedge clk) begin
    timer_result_t e;
    if (rst) begin
      bank_on = 1'b0;
      in_use = 6'd16;
      clear_timers();
      due_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ENABLE) begin
          clear_timers();
          bank_on = cfg_data[0];
        end else begin
          in_use = cfg_data;
        end
      end
      if (in_valid && in_ready)
        run_command(opcode, target, period, loop_limit, delayed_mode, elapsed_ms);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: kind %0d status %0d slot %0d", kind, status, slot);
          errors++;
        end else begin
          e = due_q.pop_front();
          if (kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, kind);
            errors++;
          end
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
          end
          if (slot !== e.slot) begin
            $error("slot: expected %0d, got %0d", e.slot, slot);
            errors++;
          end
          if (remaining !== e.rem) begin
            $error("remaining: expected %0h, got %0h", e.rem, remaining);
            errors++;
          end
          if (last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last);
            errors++;
          end
        end
      end
    end
    outstanding = due_q.size();
  end

endmodule

### sim/periodic_timer_bank_top_tb.sv
// Testbench top for the periodic timer bank: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module periodic_timer_bank_top_tb
  import ptb_pkg::*;
();

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  opcode;
  logic [5:0]  target;
  logic [31:0] period;
  logic [31:0] loop_limit;
  logic        delayed_mode;
  logic [31:0] elapsed_ms;
  logic        out_valid;
  logic        out_ready;
  logic        kind;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [31:0] remaining;
  logic        last;
  logic        cfg_we;
  logic        cfg_index;
  logic [5:0]  cfg_data;
  int          errors;
  int          outstanding;

  int          send_idle;
  int          recv_stall;
  logic        hold_req;
  int          hold_left;
  bit          hold_done;
  int          live;

  periodic_timer_bank_top i_dut (.*);

  periodic_timer_bank_checker i_checker (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_req && !hold_done && hold_left == 0) begin
      out_ready <= 1'b0;
      hold_left <= 400;
      hold_done <= 1;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  task automatic send_cmd(logic [3:0] op, logic [5:0] id, logic [31:0] per,
                          logic [31:0] loops, logic dly, logic [31:0] el);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    opcode <= op;
    target <= id;
    period <= per;
    loop_limit <= loops;
    delayed_mode <= dly;
    elapsed_ms <= el;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [5:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IN_USE) live = (value < 16) ? value : 16;
  endtask

  task automatic send_random();
    logic [3:0]  op;
    logic [5:0]  id;
    logic [31:0] per;
    logic [31:0] loops;
    logic [31:0] el;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 14) op = OP_CREATE;
    else if (pick < 22) op = OP_DELETE;
    else if (pick < 36) op = OP_START;
    else if (pick < 42) op = OP_STOP;
    else if (pick < 50) op = OP_PAUSE;
    else if (pick < 57) op = OP_RESUME;
    else if (pick < 65) op = OP_SET_PER;
    else if (pick < 70) op = OP_SET_LPS;
    else if (pick < 78) op = OP_READ;
    else if (pick < 92) op = OP_TICK;
    else if (pick < 98) op = OP_FLUSH;
    else op = OP_LAST + 4'($urandom_range(1, 5));
    id = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, live - 1)) : 6'($urandom);
    pick = $urandom_range(0, 99);
    per = (pick < 85) ? $urandom_range(1, 20) : (pick < 90) ? 32'd0 : $urandom;
    pick = $urandom_range(0, 99);
    loops = (pick < 60) ? 32'd0 : (pick < 90) ? $urandom_range(1, 4) : $urandom;
    pick = $urandom_range(0, 99);
    el = (pick < 70) ? $urandom_range(0, 8) : (pick < 90) ? $urandom_range(0, 30) : $urandom;
    send_cmd(op, id, per, loops, 1'($urandom), el);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    target = '0;
    period = '0;
    loop_limit = '0;
    delayed_mode = 1'b0;
    elapsed_ms = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    hold_req = 1'b0;
    live = 16;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send_cmd(OP_READ, 6'd0, '0, '0, 1'b0, '0);
    write_reg(CFG_ENABLE, 6'd1);
    write_reg(CFG_IN_USE, 6'd2);
    send_cmd(OP_CREATE, 6'd0, 32'd0, 32'd1, 1'b0, '0);
    send_cmd(OP_CREATE, 6'd0, 32'd3, 32'd2, 1'b0, '0);
    send_cmd(OP_CREATE, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '0);
    send_cmd(OP_CREATE, 6'd0, 32'd7, 32'd0, 1'b0, '0);
    write_reg(CFG_IN_USE, 6'd16);
    send_cmd(OP_LAST + 4'd5, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 6'd5, '0, '0, 1'b0, '0);
    send_cmd(OP_PAUSE, 6'd5, '0, '0, 1'b0, '0);
    send_cmd(OP_RESUME, 6'd0, '0, '0, 1'b0, '0);
    send_cmd(OP_STOP, 6'd0, '0, '0, 1'b0, '0);
    send_cmd(OP_START, 6'd0, '0, '0, 1'b0, '0);
    send_cmd(OP_START, 6'd0, '0, '0, 1'b0, '0);
    send_cmd(OP_START, 6'd1, '0, '0, 1'b0, '0);
    send_cmd(OP_PAUSE, 6'd1, '0, '0, 1'b0, '0);
    send_cmd(OP_SET_PER, 6'd1, 32'd1, '0, 1'b0, '0);
    send_cmd(OP_RESUME, 6'd1, '0, '0, 1'b0, '0);
    send_cmd(OP_SET_PER, 6'd1, 32'd2, '0, 1'b0, '0);
    send_cmd(OP_SET_PER, 6'd0, 32'd1, '0, 1'b0, '0);
    send_cmd(OP_SET_PER, 6'd0, 32'd0, '0, 1'b0, '0);
    send_cmd(OP_READ, 6'd1, '0, '0, 1'b0, '0);
    send_cmd(OP_TICK, 6'd0, '0, '0, 1'b0, 32'd5);
    send_cmd(OP_TICK, 6'd0, '0, '0, 1'b0, 32'hFFFF_FFFF);
    send_cmd(OP_DELETE, 6'd1, '0, '0, 1'b0, '0);
    send_cmd(OP_FLUSH, 6'd0, '0, '0, 1'b0, '0);
    send_cmd(OP_SET_LPS, 6'h3F, 32'd1, 32'd3, 1'b0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_reg(CFG_IN_USE, 6'd16);
        1: write_reg(CFG_IN_USE, 6'd63);
        2: begin
          write_reg(CFG_ENABLE, 6'd0);
          send_cmd(OP_CREATE, 6'd0, 32'd4, '0, 1'b0, '0);
          send_cmd(OP_TICK, 6'd0, '0, '0, 1'b0, 32'd1);
          write_reg(CFG_ENABLE, 6'd1);
          write_reg(CFG_IN_USE, 6'd1);
        end
        default: write_reg(CFG_IN_USE, 6'd5);
      endcase
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 75 : 8) : 0;
      recv_stall = (ph == 2) ? 75 : (ph == 3) ? 8 : 0;
      for (int k = 0; k < 60; k++) begin
        if (ph == 0 && k == 20) hold_req <= 1'b1;
        send_random();
      end
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
